>>> hw/rtl/lmad_pkg.sv
// Shared types, constants and helpers for the light mask accumulator.
// Used by lmad_ctrl, lmad_datapath and the top level; no dependencies.
`default_nettype none

package lmad_pkg;

  // Map geometry and light limits
  localparam int MAP_WIDTH    = 85;
  localparam int MAP_HEIGHT   = 64;
  localparam int SCALE_FACTOR = 3;
  localparam int MAX_RADIUS   = 21;

  localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int XW        = $clog2(MAP_WIDTH + 1);
  localparam int YW        = $clog2(MAP_HEIGHT + 1);

  // Port field widths
  localparam int PW        = 13;   // positions and camera offsets
  localparam int LW        = 8;    // cell level
  localparam int RADW      = 8;    // radius field
  localparam int CMDW      = 2;
  localparam int CFG_IW    = 1;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  // Falloff arithmetic
  localparam int RW   = $clog2(MAX_RADIUS + 1);  // clamped radius
  localparam int R2W  = 2 * RW;                  // radius squared
  localparam int NW   = R2W + 8;                 // 255 * d2
  localparam int RCPW = NW + 1;                  // 2^NW / r2
  localparam int DCW  = $clog2(NW + 1);
  localparam int DXW  = RW + 1;                  // signed offset from center

  // Divide by SCALE_FACTOR through a reciprocal
  localparam int NUMW        = 18;
  localparam int SH          = NUMW + 3;
  localparam int SCALE_RECIP = (2 ** SH + SCALE_FACTOR - 1) / SCALE_FACTOR;
  localparam int RCW         = SH + 1;
  localparam int BW          = NUMW + 1;

  localparam int TILE_SHIFT = 4;
  localparam int TILE_SIDE  = 1 + 15 / SCALE_FACTOR;

  localparam logic [LW-1:0] FULL = 8'hFF;

  typedef enum logic [CMDW-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LIGHT = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_CAMERA_X = 1'b0,
    REG_CAMERA_Y = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_BOUND,
    ST_DSTART,
    ST_DWAIT,
    ST_START,
    ST_SWEEP,
    ST_QREAD,
    ST_QOUT
  } state_t;

  typedef struct packed {
    cmd_t op;
    logic load;
    logic calc;
    logic bound;
    logic div_start;
    logic walk_start;
    logic out_load;
  } lmad_ctl_t;

  typedef struct packed {
    logic empty;
    logic div_busy;
    logic busy;
  } lmad_stat_t;

  // 4x4 ordered dither thresholds, index = row*4 + col
  localparam logic [3:0] BAYER4 [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  // Signed divide by SCALE_FACTOR, truncating toward zero
  function automatic logic signed [NUMW-1:0] div_scale(input logic signed [NUMW-1:0] num);
    logic [NUMW-1:0]     mag;
    logic [NUMW+RCW-1:0] prod;
    logic [NUMW-1:0]     quo;
    mag  = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    prod = mag * RCW'(SCALE_RECIP);
    quo  = prod[SH +: NUMW];
    return num[NUMW-1] ? $signed(NUMW'(-quo)) : $signed(quo);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/light_mask_accumulator_dither_unit.sv
// Light mask accumulator with 4x4 ordered dither, top level.
// Per request: a query reads the map and stalls until the result register is free; a clear sweeps
// all MAP_WIDTH*MAP_HEIGHT cells; a light runs setup, the divider, the sweep and the drain, with
// cells = clipped (2r)^2 up to 1764; fill runs setup and the sweep; empty region skips the sweep.
// One cell/cycle, one request at a time. Reset (rst, synchronous): camera offsets to 0, then a
// clearing pass over the map with s_tready low; configuration writes are taken at any time.
`default_nettype none

module light_mask_accumulator_dither_unit (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lmad_pkg::S_TDATA_W-1:0]  s_tdata,   // pos_x[12:0], pos_y[25:13], radius[33:26]
  input  logic [lmad_pkg::CMDW-1:0]       s_tuser,   // command[1:0]
  // result stream (query only)
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [lmad_pkg::M_TDATA_W-1:0]  m_tdata,   // blocked[0], level[8:1]
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [lmad_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [lmad_pkg::PW-1:0]         cfg_data
);

  import lmad_pkg::*;

  lmad_ctl_t  ctl;
  lmad_stat_t stat;

  logic signed [PW-1:0] pos_x, pos_y;
  logic [RADW-1:0]      radius;
  cmd_t                 command;

  // unpack the request
  assign pos_x   = $signed(s_tdata[PW-1:0]);
  assign pos_y   = $signed(s_tdata[2*PW-1:PW]);
  assign radius  = s_tdata[2*PW+RADW-1:2*PW];
  assign command = cmd_t'(s_tuser);

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [LW-1:0] ram_wdata, ram_rdata;
  logic          out_blocked;
  logic [LW-1:0] out_level;

  // Sequencer: setup steps, divider wait, sweep until the pipeline drains,
  // and the query handoff into the output register.
  lmad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (command),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl),
    .stat     (stat)
  );

  // Arithmetic, cell walker, 4-stage falloff pipeline with read-modify-write
  // of the map, and the query result register.
  lmad_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    ($signed(cfg_data)),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .radius      (radius),
    .ctl         (ctl),
    .stat        (stat),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_blocked (out_blocked),
    .out_level   (out_level)
  );

  // Brightness map, one byte per cell, row-major
  lmad_ram #(
    .WIDTH (LW),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tdata = {{(M_TDATA_W - LW - 1){1'b0}}, out_level, out_blocked};

endmodule

`default_nettype wire

>>> hw/rtl/lmad_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lmad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lmad_ctrl.sv
// Command sequencer for the light mask accumulator.
// Depends on lmad_pkg; drives lmad_datapath through lmad_ctl_t.
`default_nettype none

module lmad_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  lmad_pkg::cmd_t      command,
  output logic                m_tvalid,
  input  logic                m_tready,
  output lmad_pkg::lmad_ctl_t ctl,
  input  lmad_pkg::lmad_stat_t stat
);

  import lmad_pkg::*;

  state_t state, state_next;
  cmd_t   op, op_next;

  // reset starts with a clear sweep of the map
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      op    <= CMD_CLEAR;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    ctl        = '0;
    ctl.op     = op;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load = 1'b1;
          op_next  = command;
          unique case (command)
            CMD_CLEAR:           state_next = ST_START;
            CMD_LIGHT, CMD_FILL: state_next = ST_CALC;
            CMD_QUERY:           state_next = ST_QREAD;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        ctl.calc   = 1'b1;
        state_next = ST_BOUND;
      end
      ST_BOUND: begin
        ctl.bound  = 1'b1;
        state_next = (op == CMD_LIGHT) ? ST_DSTART : ST_START;
      end
      ST_DSTART: begin
        ctl.div_start = 1'b1;
        state_next    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (!stat.div_busy) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (stat.empty) begin
          state_next = ST_IDLE;
        end else begin
          ctl.walk_start = 1'b1;
          state_next     = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!stat.busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_QREAD: begin
        state_next = ST_QOUT;
      end
      ST_QOUT: begin
        if (!m_tvalid || m_tready) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/lmad_datapath.sv
// Datapath: camera registers, setup arithmetic, reciprocal divider, cell walker,
// falloff pipeline and query result. Depends on lmad_pkg; map RAM is outside.
`default_nettype none

module lmad_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [lmad_pkg::CFG_IW-1:0]    cfg_index,
  input  logic signed [lmad_pkg::PW-1:0] cfg_data,
  input  logic signed [lmad_pkg::PW-1:0] pos_x,
  input  logic signed [lmad_pkg::PW-1:0] pos_y,
  input  logic [lmad_pkg::RADW-1:0]      radius,
  input  lmad_pkg::lmad_ctl_t            ctl,
  output lmad_pkg::lmad_stat_t           stat,
  output logic                           ram_we,
  output logic [lmad_pkg::AW-1:0]        ram_waddr,
  output logic [lmad_pkg::LW-1:0]        ram_wdata,
  output logic [lmad_pkg::AW-1:0]        ram_raddr,
  input  logic [lmad_pkg::LW-1:0]        ram_rdata,
  output logic                           out_blocked,
  output logic [lmad_pkg::LW-1:0]        out_level
);

  import lmad_pkg::*;

  logic is_light, is_fill, is_clear, is_query;
  assign is_light = (ctl.op == CMD_LIGHT);
  assign is_fill  = (ctl.op == CMD_FILL);
  assign is_clear = (ctl.op == CMD_CLEAR);
  assign is_query = (ctl.op == CMD_QUERY);

  // ---------------- camera offsets ----------------
  logic signed [PW-1:0] cam_x, cam_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CAMERA_X: cam_x <= cfg_data;
        REG_CAMERA_Y: cam_y <= cfg_data;
      endcase
    end
  end

  // ---------------- request capture ----------------
  logic signed [PW-1:0] lpx, lpy;
  logic [RADW-1:0]      lrad;
  logic [AW-1:0]        qaddr;
  logic                 qin;
  logic [3:0]           qdix;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lpx   <= pos_x;
      lpy   <= pos_y;
      lrad  <= radius;
      qaddr <= AW'(pos_y[YW-1:0] * MAP_WIDTH) + AW'(pos_x[XW-1:0]);
      qin   <= (pos_x >= 0) && (pos_x < MAP_WIDTH) && (pos_y >= 0) && (pos_y < MAP_HEIGHT);
      qdix  <= {2'(pos_y[1:0] + cam_y[1:0]), 2'(pos_x[1:0] + cam_x[1:0])};
    end
  end

  // ---------------- center / corner and radius ----------------
  logic signed [NUMW-1:0] numx, numy, numr, rdiv;
  logic signed [NUMW-1:0] cx, cy;
  logic [RW-1:0]          r_clamp, r;

  always_comb begin
    if (is_fill) begin
      numx = (NUMW'(lpx) <<< TILE_SHIFT) - NUMW'(cam_x);
      numy = (NUMW'(lpy) <<< TILE_SHIFT) - NUMW'(cam_y);
    end else begin
      numx = NUMW'(lpx) - NUMW'(cam_x);
      numy = NUMW'(lpy) - NUMW'(cam_y);
    end
    numr = $signed(NUMW'(lrad));
    rdiv = div_scale(numr);
    if (rdiv < 1) begin
      r_clamp = RW'(1);
    end else if (rdiv > MAX_RADIUS) begin
      r_clamp = RW'(MAX_RADIUS);
    end else begin
      r_clamp = rdiv[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      cx <= div_scale(numx);
      cy <= div_scale(numy);
      r  <= r_clamp;
    end
  end

  // ---------------- clipped region ----------------
  logic signed [BW-1:0] cxw, cyw, rs, ext_lo, ext_hi;
  logic signed [BW-1:0] lo_x, hi_x, lo_y, hi_y, lo_xc, hi_xc, lo_yc, hi_yc;
  logic [XW-1:0]        bx_lo, bx_hi;
  logic [YW-1:0]        by_lo, by_hi;
  logic                 empty_r;
  logic [R2W-1:0]       r2;

  always_comb begin
    cxw    = BW'(cx);
    cyw    = BW'(cy);
    rs     = $signed(BW'(r));
    ext_lo = is_light ? rs : '0;
    ext_hi = is_light ? rs : BW'(TILE_SIDE);
    lo_x   = cxw - ext_lo;
    hi_x   = cxw + ext_hi;
    lo_y   = cyw - ext_lo;
    hi_y   = cyw + ext_hi;
    lo_xc  = (lo_x < 0) ? '0 : lo_x;
    lo_yc  = (lo_y < 0) ? '0 : lo_y;
    hi_xc  = (hi_x > BW'(MAP_WIDTH)) ? BW'(MAP_WIDTH) : hi_x;
    hi_yc  = (hi_y > BW'(MAP_HEIGHT)) ? BW'(MAP_HEIGHT) : hi_y;
  end

  always_ff @(posedge clk) begin
    if (ctl.bound) begin
      bx_lo   <= XW'(lo_xc);
      bx_hi   <= XW'(hi_xc);
      by_lo   <= YW'(lo_yc);
      by_hi   <= YW'(hi_yc);
      empty_r <= (lo_xc >= hi_xc) || (lo_yc >= hi_yc);
      r2      <= r * r;
    end
  end

  // ---------------- reciprocal 2^NW / r2, one bit per cycle ----------------
  logic            div_busy;
  logic [DCW-1:0]  div_cnt;
  logic [R2W-1:0]  div_rem;
  logic [RCPW-1:0] recip;
  logic [R2W:0]    rem_sh, rem_new;
  logic            fits;

  always_comb begin
    rem_sh  = {div_rem, (div_cnt == DCW'(NW))};
    fits    = (rem_sh >= {1'b0, r2});
    rem_new = fits ? rem_sh - {1'b0, r2} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (ctl.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == '0) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      div_cnt <= DCW'(NW);
      div_rem <= '0;
      recip   <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
      div_rem <= rem_new[R2W-1:0];
      recip   <= {recip[RCPW-2:0], fits};
    end
  end

  // ---------------- cell walker ----------------
  logic                  walking;
  logic [XW-1:0]         wx, xl, xh;
  logic [YW-1:0]         wy, yl, yh;
  logic [AW-1:0]         waddr, rowbase;
  logic signed [DXW-1:0] wdx, wdy, dx0, dy0;
  logic signed [BW-1:0]  xlw, ylw;
  logic                  x_end, y_end;

  always_comb begin
    xl    = is_clear ? '0 : bx_lo;
    xh    = is_clear ? XW'(MAP_WIDTH) : bx_hi;
    yl    = is_clear ? '0 : by_lo;
    yh    = is_clear ? YW'(MAP_HEIGHT) : by_hi;
    xlw   = BW'(xl);
    ylw   = BW'(yl);
    dx0   = DXW'(xlw - cxw);
    dy0   = DXW'(ylw - cyw);
    x_end = (XW'(wx + 1'b1) == xh);
    y_end = (YW'(wy + 1'b1) == yh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
    end else if (ctl.walk_start) begin
      walking <= 1'b1;
    end else if (walking && x_end && y_end) begin
      walking <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_start) begin
      wx      <= xl;
      wy      <= yl;
      rowbase <= AW'(yl * MAP_WIDTH);
      waddr   <= AW'(yl * MAP_WIDTH) + AW'(xl);
      wdx     <= dx0;
      wdy     <= dy0;
    end else if (walking) begin
      if (x_end) begin
        wx      <= xl;
        wy      <= YW'(wy + 1'b1);
        rowbase <= AW'(rowbase + AW'(MAP_WIDTH));
        waddr   <= AW'(rowbase + AW'(MAP_WIDTH) + AW'(xl));
        wdx     <= dx0;
        wdy     <= DXW'(wdy + 1);
      end else begin
        wx    <= XW'(wx + 1'b1);
        waddr <= AW'(waddr + 1'b1);
        wdx   <= DXW'(wdx + 1);
      end
    end
  end

  // ---------------- falloff pipeline ----------------
  logic                vld1, vld2, vld3, vld4;
  logic [AW-1:0]       addr1, addr2, addr3, addr4;
  logic [R2W:0]        d2_1;
  logic                inr2, inr3;
  logic [NW-1:0]       nval2, nval3;
  logic [LW-1:0]       qest3, bval4;
  logic signed [R2W:0] dxe, dye;
  logic [R2W:0]        sqx, sqy;
  logic [NW+RCPW-1:0]  prod;
  logic [NW-1:0]       qr, rem3;
  logic [LW-1:0]       qfix, bval;

  always_comb begin
    dxe  = wdx;
    dye  = wdy;
    sqx  = dxe * dxe;
    sqy  = dye * dye;
    prod = nval2 * recip;
    qr   = qest3 * r2;
    rem3 = nval3 - qr;
    qfix = qest3 + LW'(rem3 >= NW'(r2));
    bval = inr3 ? (FULL - qfix) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
    end else begin
      vld1 <= walking;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    addr1 <= waddr;
    d2_1  <= sqx + sqy;
    addr2 <= addr1;
    inr2  <= (d2_1 < {1'b0, r2});
    nval2 <= NW'({d2_1[R2W-1:0], 8'b0}) - NW'(d2_1[R2W-1:0]);
    addr3 <= addr2;
    inr3  <= inr2;
    nval3 <= nval2;
    qest3 <= prod[NW +: LW];
    addr4 <= addr3;
    bval4 <= bval;
  end

  // read issued from stage 3 so the old level lines up with stage 4
  assign ram_raddr = is_query ? qaddr : addr3;
  assign ram_waddr = addr4;
  assign ram_we    = vld4 && (!is_light || (ram_rdata < bval4));
  assign ram_wdata = is_clear ? '0 : (is_fill ? FULL : bval4);

  assign stat.empty    = is_clear ? 1'b0 : empty_r;
  assign stat.div_busy = div_busy;
  assign stat.busy     = walking | vld1 | vld2 | vld3 | vld4;

  // ---------------- query result ----------------
  logic [LW-1:0] qlevel;
  assign qlevel = qin ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_level   <= qlevel;
      out_blocked <= (qlevel[LW-1:3] <= {1'b0, BAYER4[qdix]});
    end
  end

endmodule

`default_nettype wire
